@@ sv/hwp_pkg.sv @@
package hwp_pkg;

    // Fixed limit on the radius register.
    localparam int MAX_RADIUS = 127;

    // Pipeline stage map. CORDIC steps run alongside the divider steps.
    localparam int ATAN_LEN    = 24;
    localparam int DIV_FIRST   = 3;
    localparam int DIV_STEPS   = 33;
    localparam int SQRT_FIRST  = DIV_FIRST + DIV_STEPS;
    localparam int SQRT_STEPS  = 17;
    localparam int COLOR_FIRST = SQRT_FIRST + SQRT_STEPS;
    localparam int NUM_STAGES  = COLOR_FIRST + 4;

    localparam logic [24:0] HUE_HALF   = 25'd11796480;
    localparam logic [22:0] QUAD_Q16   = 23'd5898240;
    localparam logic [15:0] HUE_FULL   = 16'd23040;
    localparam logic [11:0] HUE_SECTOR = 12'd3840;
    localparam logic [20:0] RECIP15    = 21'd1118482;
    localparam logic [16:0] ONE_Q16    = 17'h10000;

    localparam logic [1:0] CFG_RADIUS     = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;

    typedef logic [22:0] t_atan;

    // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
    localparam t_atan ATAN_TABLE [0:ATAN_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

    typedef struct packed {
        logic [6:0] radius;
        logic [7:0] brightness;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0]  dx;
        logic signed [7:0]  dy;
        logic [7:0]         ax;
        logic [7:0]         ay;
        logic               center;
        logic [15:0]        m2;
        logic [13:0]        r2;
        logic [14:0]        rem;
        logic [13:0]        den;
        logic [32:0]        quo;
        logic signed [29:0] cx;
        logic signed [29:0] cy;
        logic signed [23:0] cz;
        logic [24:0]        hue;
        logic [14:0]        h64;
        logic [2:0]         sector;
        logic [11:0]        ramp;
        logic [19:0]        srem;
        logic [16:0]        root;
        logic [27:0]        prod;
        logic [16:0]        mval;
        logic [16:0]        xv;
        logic [16:0]        c0;
        logic [16:0]        c1;
        logic [16:0]        c2;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_pipe;

endpackage

@@ sv/hwp_stage.sv @@
module hwp_stage import hwp_pkg::*; #(
    parameter int K    = 0,
    parameter int ITER = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_valid,
    input  t_pipe i_item,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_pipe o_item
);

    localparam int HUE_A = DIV_FIRST + ITER;
    localparam int DJ = (K >= DIV_FIRST && K < DIV_FIRST + DIV_STEPS) ? K - DIV_FIRST : 0;
    localparam int CI = (K >= DIV_FIRST && K < DIV_FIRST + ITER) ? K - DIV_FIRST : 0;
    localparam int SJ = (K >= SQRT_FIRST && K < SQRT_FIRST + SQRT_STEPS) ? K - SQRT_FIRST : 0;

    t_pipe r_item, n_item;
    logic  r_valid, n_valid;

    always_comb begin
        logic [6:0]         rad;
        logic               in_wheel;
        logic [14:0]        dtrial;
        logic signed [29:0] xs;
        logic signed [29:0] ys;
        logic [22:0]        th;
        logic [25:0]        hsum;
        logic [15:0]        hq;
        logic [33:0]        qq;
        logic [19:0]        rem4;
        logic [19:0]        strial;
        logic [19:0]        nq;
        logic [40:0]        p41;
        logic [16:0]        ch0, ch1, ch2;
        logic [17:0]        s0, s1, s2;
        logic [24:0]        b0, b1, b2;

        n_item = i_item;
        rad    = (i_cfg.radius > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : i_cfg.radius;
        in_wheel = (i_item.m2 <= {2'b00, i_item.r2});
        dtrial = '0;
        xs = '0; ys = '0; th = '0; hsum = '0; hq = '0;
        qq = {1'b0, i_item.quo};
        rem4 = '0; strial = '0; nq = '0; p41 = '0;
        ch0 = '0; ch1 = '0; ch2 = '0; s0 = '0; s1 = '0; s2 = '0;
        b0 = '0; b1 = '0; b2 = '0;

        if (K == 1) begin
            n_item.ax = i_item.dx[7] ? 8'(-i_item.dx) : 8'(i_item.dx);
            n_item.ay = i_item.dy[7] ? 8'(-i_item.dy) : 8'(i_item.dy);
            n_item.m2 = 16'({8'd0, n_item.ax} * {8'd0, n_item.ax})
                      + 16'({8'd0, n_item.ay} * {8'd0, n_item.ay});
            n_item.r2 = 14'({7'd0, rad} * {7'd0, rad});
            n_item.center = (i_item.dx == 8'sd0) && (i_item.dy == 8'sd0);
        end

        if (K == 2) begin
            n_item.rem  = i_item.m2[14:0];
            n_item.den  = (i_item.r2 == 14'd0) ? 14'd1 : i_item.r2;
            n_item.quo  = '0;
            n_item.cx   = signed'({2'b00, i_item.ax, 20'd0});
            n_item.cy   = signed'({2'b00, i_item.ay, 20'd0});
            n_item.cz   = '0;
            n_item.srem = '0;
            n_item.root = '0;
        end

        // Restoring division, one quotient bit per stage.
        if (K >= DIV_FIRST && K < DIV_FIRST + DIV_STEPS) begin
            dtrial = (DJ == 0) ? i_item.rem : {i_item.rem[13:0], 1'b0};
            if (dtrial >= {1'b0, i_item.den}) begin
                n_item.quo[32-DJ] = 1'b1;
                n_item.rem        = dtrial - {1'b0, i_item.den};
            end else begin
                n_item.rem = dtrial;
            end
        end

        // Vectoring CORDIC, one rotation per stage.
        if (K >= DIV_FIRST && K < DIV_FIRST + ITER) begin
            xs = i_item.cx >>> CI;
            ys = i_item.cy >>> CI;
            if (!i_item.cy[29]) begin
                n_item.cx = i_item.cx + ys;
                n_item.cy = i_item.cy - xs;
                n_item.cz = i_item.cz + signed'({1'b0, ATAN_TABLE[CI]});
            end else begin
                n_item.cx = i_item.cx - ys;
                n_item.cy = i_item.cy + xs;
                n_item.cz = i_item.cz - signed'({1'b0, ATAN_TABLE[CI]});
            end
        end

        // Clamp the first-quadrant angle and map it around the wheel.
        if (K == HUE_A) begin
            if (i_item.cz[23]) begin
                th = '0;
            end else if (i_item.cz > signed'({1'b0, QUAD_Q16})) begin
                th = QUAD_Q16;
            end else begin
                th = i_item.cz[22:0];
            end
            if (i_item.center) begin
                n_item.hue = HUE_HALF;
            end else begin
                case ({i_item.dx[7], i_item.dy[7]})
                    2'b00:   n_item.hue = HUE_HALF + {2'b00, th};
                    2'b01:   n_item.hue = HUE_HALF - {2'b00, th};
                    2'b10:   n_item.hue = {HUE_HALF[23:0], 1'b0} - {2'b00, th};
                    default: n_item.hue = {2'b00, th};
                endcase
            end
        end

        if (K == HUE_A + 1) begin
            hsum = {1'b0, i_item.hue} + 26'd512;
            hq   = hsum[25:10];
            if (hq >= HUE_FULL) begin
                n_item.h64 = '0;
            end else begin
                n_item.h64 = hq[14:0];
            end
        end

        if (K == HUE_A + 2) begin
            if (i_item.h64 >= 15'(5 * HUE_SECTOR)) begin
                n_item.sector = 3'd5;
                n_item.ramp   = 12'(i_item.h64 - 15'(5 * HUE_SECTOR));
            end else if (i_item.h64 >= 15'(4 * HUE_SECTOR)) begin
                n_item.sector = 3'd4;
                n_item.ramp   = 12'(i_item.h64 - 15'(4 * HUE_SECTOR));
            end else if (i_item.h64 >= 15'(3 * HUE_SECTOR)) begin
                n_item.sector = 3'd3;
                n_item.ramp   = 12'(i_item.h64 - 15'(3 * HUE_SECTOR));
            end else if (i_item.h64 >= 15'(2 * HUE_SECTOR)) begin
                n_item.sector = 3'd2;
                n_item.ramp   = 12'(i_item.h64 - 15'(2 * HUE_SECTOR));
            end else if (i_item.h64 >= 15'(HUE_SECTOR)) begin
                n_item.sector = 3'd1;
                n_item.ramp   = 12'(i_item.h64 - 15'(HUE_SECTOR));
            end else begin
                n_item.sector = 3'd0;
                n_item.ramp   = i_item.h64[11:0];
            end
            if (n_item.sector[0]) begin
                n_item.ramp = HUE_SECTOR - n_item.ramp;
            end
        end

        // Digit-recurrence square root, one result bit per stage.
        if (K >= SQRT_FIRST && K < SQRT_FIRST + SQRT_STEPS) begin
            rem4   = {i_item.srem[17:0], qq[33-2*SJ -: 2]};
            strial = {1'b0, i_item.root, 2'b01};
            if (rem4 >= strial) begin
                n_item.srem = rem4 - strial;
                n_item.root = {i_item.root[15:0], 1'b1};
            end else begin
                n_item.srem = rem4;
                n_item.root = {i_item.root[15:0], 1'b0};
            end
        end

        if (K == COLOR_FIRST) begin
            n_item.prod = 28'({12'd0, i_item.root} * {17'd0, i_item.ramp});
            n_item.mval = ONE_Q16 - i_item.root;
        end

        // Division by 3840: drop eight bits, then multiply by a reciprocal of 15.
        if (K == COLOR_FIRST + 1) begin
            nq = i_item.prod[27:8];
            p41 = {21'd0, nq} * {20'd0, RECIP15};
            n_item.xv = p41[40:24];
        end

        if (K == COLOR_FIRST + 2) begin
            case (i_item.sector)
                3'd0: begin ch0 = i_item.root; ch1 = i_item.xv;   ch2 = '0;          end
                3'd1: begin ch0 = i_item.xv;   ch1 = i_item.root; ch2 = '0;          end
                3'd2: begin ch0 = '0;          ch1 = i_item.root; ch2 = i_item.xv;   end
                3'd3: begin ch0 = '0;          ch1 = i_item.xv;   ch2 = i_item.root; end
                3'd4: begin ch0 = i_item.xv;   ch1 = '0;          ch2 = i_item.root; end
                default: begin ch0 = i_item.root; ch1 = '0;       ch2 = i_item.xv;   end
            endcase
            s0 = {1'b0, ch0} + {1'b0, i_item.mval};
            s1 = {1'b0, ch1} + {1'b0, i_item.mval};
            s2 = {1'b0, ch2} + {1'b0, i_item.mval};
            n_item.c0 = (s0 > {1'b0, ONE_Q16}) ? ONE_Q16 : s0[16:0];
            n_item.c1 = (s1 > {1'b0, ONE_Q16}) ? ONE_Q16 : s1[16:0];
            n_item.c2 = (s2 > {1'b0, ONE_Q16}) ? ONE_Q16 : s2[16:0];
        end

        if (K == COLOR_FIRST + 3) begin
            b0 = {8'd0, i_item.c0} * {17'd0, i_cfg.brightness};
            b1 = {8'd0, i_item.c1} * {17'd0, i_cfg.brightness};
            b2 = {8'd0, i_item.c2} * {17'd0, i_cfg.brightness};
            n_item.red   = b0[23:16];
            n_item.green = b1[23:16];
            n_item.blue  = b2[23:16];
        end

        // Pixels outside the wheel are dropped right after the inside test.
        n_valid = i_valid && ((K != 2) || in_wheel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/hue_wheel_pixel_generator.sv @@
// Hue wheel pixel generator.
//
// Input channel (i_valid / o_ready, fields i_dx, i_dy): one pixel offset from the
// wheel center per transfer. Output channel (o_valid / i_ready): the echoed offset
// and its red, green and blue channels. Pixels outside the radius give no output
// transfer. The user writes the radius (index 0) and brightness scale (index 1)
// over the configuration port only while idle; the block does not enforce it.
//
// Throughput is one pixel per clock while the receiver keeps i_ready high. Every
// CORDIC rotation, every quotient bit of the saturation divider and every
// square-root bit has a register stage of its own, so the block is a 57-stage
// pipeline.
//
// Reset clears every stage valid bit, sets the radius to 65 and the brightness
// to 255. When the receiver stalls, the output register holds its result and
// the stages behind it keep moving until they fill up, so empty slots collapse
// and o_ready drops only once the whole pipeline is full.
module hue_wheel_pixel_generator import hwp_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [7:0] i_dx,
    input  logic signed [7:0] i_dy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_pix_dx,
    output logic signed [7:0] o_pix_dy,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_wdata
);

    t_cfg  r_cfg;
    t_pipe in_item;
    t_pipe stage_item [NUM_STAGES];
    logic [NUM_STAGES-1:0] stage_valid;
    logic [NUM_STAGES:0]   advance;

    // Configuration registers. Unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius     <= 7'd65;
            r_cfg.brightness <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS:     r_cfg.radius     <= i_cfg_wdata[6:0];
                CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        in_item    = '0;
        in_item.dx = i_dx;
        in_item.dy = i_dy;
    end

    // A stage loads when it is empty or the stage after it is moving.
    assign advance[NUM_STAGES] = i_ready;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        assign advance[k] = !stage_valid[k] || advance[k+1];

        if (k == 0) begin : g_first
            hwp_stage #(.K(k), .ITER(ANGLE_ITERATIONS)) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (advance[k]),
                .i_valid (i_valid),
                .i_item  (in_item),
                .i_cfg   (r_cfg),
                .o_valid (stage_valid[k]),
                .o_item  (stage_item[k])
            );
        end else begin : g_next
            hwp_stage #(.K(k), .ITER(ANGLE_ITERATIONS)) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (advance[k]),
                .i_valid (stage_valid[k-1]),
                .i_item  (stage_item[k-1]),
                .i_cfg   (r_cfg),
                .o_valid (stage_valid[k]),
                .o_item  (stage_item[k])
            );
        end
    end

    assign o_ready  = advance[0];
    assign o_valid  = stage_valid[NUM_STAGES-1];
    assign o_pix_dx = stage_item[NUM_STAGES-1].dx;
    assign o_pix_dy = stage_item[NUM_STAGES-1].dy;
    assign o_red    = stage_item[NUM_STAGES-1].red;
    assign o_green  = stage_item[NUM_STAGES-1].green;
    assign o_blue   = stage_item[NUM_STAGES-1].blue;

endmodule

@@ sv/hwp_checker.sv @@
module hwp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic signed [7:0] i_dx,
    input logic signed [7:0] i_dy,
    input logic              o_valid,
    input logic              i_ready,
    input logic signed [7:0] o_pix_dx,
    input logic signed [7:0] o_pix_dy,
    input logic [7:0]        o_red,
    input logic [7:0]        o_green,
    input logic [7:0]        o_blue,
    input logic              i_cfg_we,
    input logic [1:0]        i_cfg_index,
    input logic [7:0]        i_cfg_wdata
);

    // After reset the pipeline is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("pipeline not empty after reset");

    // Backpressure only comes from the receiver.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while the receiver is ready");

    // A stalled result is held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pix_dx) && $stable(o_pix_dy)
            && $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("stalled result changed");

    // The center pixel has zero saturation, so it is gray.
    a_center_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pix_dx == 8'sd0) && (o_pix_dy == 8'sd0)
            |-> (o_red == o_green) && (o_green == o_blue))
        else $error("center pixel is not gray");

endmodule

bind hue_wheel_pixel_generator hwp_checker u_hwp_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Hue wheel pixel generator bench: pixel offsets go in over a valid/ready
// channel, and every pixel inside the wheel must come back with its offset
// echoed and its RGB color. A behavioral color model predicts each result
// no directed row gives. Expected pixels queue in transfer order, and the
// monitor compares every output transfer field by field with the oldest entry.
module testbench;
    import hwp_pkg::*;

    localparam int         HALF_PERIOD = 10;
    localparam int         PIPE_DEPTH  = NUM_STAGES;
    localparam int         CORDIC_STEPS = 16;
    localparam int         STALL_LIMIT = 2000;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    typedef struct {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_pixel;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_OUTSIDE} t_row_kind;

    typedef struct {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        t_row_kind         kind;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic signed [7:0] i_dx;
    logic signed [7:0] i_dy;
    logic              o_valid;
    logic              i_ready;
    logic signed [7:0] o_pix_dx;
    logic signed [7:0] o_pix_dy;
    logic [7:0]        o_red;
    logic [7:0]        o_green;
    logic [7:0]        o_blue;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_wdata;

    // The bench keeps its own copy of the two registers.
    logic [6:0] wheel_radius;
    logic [7:0] wheel_bright;

    t_pixel pixel_q[$];
    int     error_count;
    int     stall_cycles;
    bit     long_hold_req;

    hue_wheel_pixel_generator i_dut (.*);

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Floor square root by the classic bit-pair method.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // First quadrant angle in degrees Q16 by vectoring CORDIC, clamped to 0..90.
    function automatic longint first_quadrant_angle(input longint ax, input longint ay);
        longint xa;
        longint ya;
        longint za;
        longint xs;
        longint ys;
        xa = ax <<< 20;
        ya = ay <<< 20;
        za = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0) begin
                xa += ys;
                ya -= xs;
                za += longint'(ATAN_TABLE[i]);
            end else begin
                xa -= ys;
                ya += xs;
                za -= longint'(ATAN_TABLE[i]);
            end
        end
        if (za < 0) za = 0;
        if (za > 90 * 65536) za = 90 * 65536;
        return za;
    endfunction

    // Computes the wheel color of one pixel; returns 0 when the pixel lies
    // outside the wheel and so produces no output transfer.
    function automatic bit wheel_color(input logic signed [7:0] dx,
                                       input logic signed [7:0] dy,
                                       output t_pixel pix);
        longint          sdx;
        longint          sdy;
        longint unsigned m2;
        longint unsigned r2;
        longint unsigned sat;
        longint          ang;
        longint          hue_q16;
        longint          h64;
        longint unsigned ramp;
        longint unsigned xv;
        longint unsigned mval;
        longint unsigned chan [3];
        longint unsigned c;
        int              sector;
        sdx  = dx;
        sdy  = dy;
        m2   = sdx * sdx + sdy * sdy;
        r2   = wheel_radius * wheel_radius;
        pix  = '{default: '0};
        if (m2 > r2) return 1'b0;
        sat = 0;
        if (r2 != 0) sat = int_sqrt((m2 << 32) / r2);
        if (sat > 65536) sat = 65536;
        // The center pixel has no direction, so it sits at half a turn.
        if (sdx == 0 && sdy == 0) begin
            hue_q16 = 180 * 65536;
        end else begin
            ang = first_quadrant_angle(sdx < 0 ? -sdx : sdx, sdy < 0 ? -sdy : sdy);
            if (sdx >= 0) hue_q16 = (sdy >= 0) ? ang : -ang;
            else          hue_q16 = (sdy >= 0) ? (180 * 65536 - ang) : (ang - 180 * 65536);
            hue_q16 += 180 * 65536;
        end
        h64 = (hue_q16 + 512) / 1024;
        if (h64 < 0) h64 = 0;
        if (h64 > HUE_FULL) h64 = HUE_FULL;
        h64    = h64 % HUE_FULL;
        sector = int'(h64 / HUE_SECTOR);
        ramp   = h64 % HUE_SECTOR;
        if (sector % 2 == 1) ramp = HUE_SECTOR - ramp;
        xv   = (sat * ramp) / HUE_SECTOR;
        mval = 65536 - sat;
        case (sector)
            0: chan = '{sat, xv, 0};
            1: chan = '{xv, sat, 0};
            2: chan = '{0, sat, xv};
            3: chan = '{0, xv, sat};
            4: chan = '{xv, 0, sat};
            default: chan = '{sat, 0, xv};
        endcase
        for (int k = 0; k < 3; k++) begin
            c = chan[k] + mval;
            if (c > 65536) c = 65536;
            chan[k] = (c * wheel_bright) >> 16;
        end
        pix.dx    = dx;
        pix.dy    = dy;
        pix.red   = chan[0][7:0];
        pix.green = chan[1][7:0];
        pix.blue  = chan[2][7:0];
        return 1'b1;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long gap.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) return 0;
        if (pick < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one pixel and waits for its transfer. The expected result is
    // queued at the accepting edge, using the registers in force then.
    task automatic offer_pixel(input logic signed [7:0] dx, input logic signed [7:0] dy,
                               input t_row_kind kind, input t_pixel typed);
        t_pixel pix;
        int     gap;
        i_valid = 1'b1;
        i_dx    = dx;
        i_dy    = dy;
        do @(posedge i_clk); while (!o_ready);
        case (kind)
            ROW_TYPED: pixel_q.push_back(typed);
            ROW_OUTSIDE: ;
            default: if (wheel_color(dx, dy, pix)) pixel_q.push_back(pix);
        endcase
        @(negedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Lets the pipeline drain completely. Pixels outside the wheel leave no
    // trace in the queue, so the bench keeps waiting after the queue empties.
    task automatic drain_pipeline();
        i_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_RADIUS)     wheel_radius = value[6:0];
        if (index == CFG_BRIGHTNESS) wheel_bright = value;
    endtask

    // Random pixels: most fall in the square around the wheel, a few land
    // at or next to the center, the rest spread over the whole offset range.
    task automatic random_pixels(input int count);
        int     r;
        int     pick;
        t_pixel none;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            r    = wheel_radius;
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                dx = 8'(int'($urandom_range(0, 2 * r)) - r);
                dy = 8'(int'($urandom_range(0, 2 * r)) - r);
            end else if (pick < 15) begin
                dx = 8'(int'($urandom_range(0, 2)) - 1);
                dy = 8'(int'($urandom_range(0, 2)) - 1);
            end else begin
                dx = 8'($urandom_range(0, 255));
                dy = 8'($urandom_range(0, 255));
            end
            offer_pixel(dx, dy, ROW_PREDICT, none);
        end
    endtask

    // Output monitor: every output transfer must match the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected output transfer dx=%0d dy=%0d", o_pix_dx, o_pix_dy);
                error_count++;
            end else begin
                want = pixel_q.pop_front();
                if (o_pix_dx !== want.dx) begin
                    $error("pix_dx expected %0d got %0d", want.dx, o_pix_dx);
                    error_count++;
                end
                if (o_pix_dy !== want.dy) begin
                    $error("pix_dy expected %0d got %0d", want.dy, o_pix_dy);
                    error_count++;
                end
                if (o_red !== want.red) begin
                    $error("red expected %0d got %0d", want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $error("green expected %0d got %0d", want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue expected %0d got %0d", want.blue, o_blue);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so that the
    // pipeline fills up and the input side has to stall.
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_ready = 1'b0;
                repeat (PIPE_DEPTH * 8) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            gap = idle_gap();
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // Watchdog: too many cycles without any transfer means the block hung.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("hue_wheel_pixel_generator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        // Directed pixels at the default radius 65 and brightness 255. The
        // center comes out at full brightness, the rim on the positive x axis
        // is pure cyan, the rim on the negative x axis pure red.
        t_row directed [] = '{
            '{8'sd0,    8'sd0,    ROW_TYPED,   8'd255, 8'd255, 8'd255},
            '{8'sd65,   8'sd0,    ROW_TYPED,   8'd0,   8'd255, 8'd255},
            '{-8'sd65,  8'sd0,    ROW_TYPED,   8'd255, 8'd0,   8'd0},
            '{8'sd66,   8'sd0,    ROW_OUTSIDE, 8'd0,   8'd0,   8'd0},
            '{-8'sd128, -8'sd128, ROW_OUTSIDE, 8'd0,   8'd0,   8'd0},
            '{8'sd127,  8'sd127,  ROW_OUTSIDE, 8'd0,   8'd0,   8'd0},
            '{8'sd0,    8'sd65,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd0,    -8'sd65,  ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd46,   8'sd46,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{-8'sd46,  -8'sd46,  ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{-8'sd46,  8'sd46,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd46,   -8'sd46,  ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd1,    8'sd0,    ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd0,    8'sd1,    ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{-8'sd1,   -8'sd1,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd30,   -8'sd40,  ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{-8'sd40,  8'sd30,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd20,   8'sd60,   ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{-8'sd60,  -8'sd20,  ROW_PREDICT, 8'd0,   8'd0,   8'd0},
            '{8'sd126,  -8'sd127, ROW_OUTSIDE, 8'd0,   8'd0,   8'd0},
            '{-8'sd128, 8'sd0,    ROW_OUTSIDE, 8'd0,   8'd0,   8'd0}
        };
        t_pixel typed;

        error_count   = 0;
        stall_cycles  = 0;
        long_hold_req = 1'b0;
        wheel_radius  = 7'd65;
        wheel_bright  = 8'd255;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_dx          = '0;
        i_dy          = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_RADIUS;
        i_cfg_wdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[n]) begin
            typed = '{directed[n].dx, directed[n].dy,
                      directed[n].red, directed[n].green, directed[n].blue};
            offer_pixel(directed[n].dx, directed[n].dy, directed[n].kind, typed);
        end
        random_pixels(40);
        drain_pipeline();

        // Largest radius, full brightness; the receiver holds off for a long
        // stretch while pixels keep coming.
        write_register(CFG_RADIUS, 8'd127);
        long_hold_req = 1'b1;
        random_pixels(120);
        drain_pipeline();

        // Radius zero: only the center is inside. The spare index is ignored.
        write_register(CFG_RADIUS, 8'd0);
        write_register(CFG_BRIGHTNESS, 8'd200);
        write_register(CFG_SPARE, 8'hFF);
        random_pixels(50);
        drain_pipeline();

        // Smallest nonzero radius with the color scaled to black.
        write_register(CFG_RADIUS, 8'd1);
        write_register(CFG_BRIGHTNESS, 8'd0);
        random_pixels(50);
        drain_pipeline();

        // Values with the upper data bit set, which the radius register drops.
        write_register(CFG_RADIUS, 8'hDA);
        write_register(CFG_BRIGHTNESS, 8'd128);
        random_pixels(70);
        drain_pipeline();

        write_register(CFG_RADIUS, 8'd37);
        write_register(CFG_BRIGHTNESS, 8'd1);
        random_pixels(40);
        drain_pipeline();

        write_register(CFG_RADIUS, 8'd100);
        write_register(CFG_BRIGHTNESS, 8'd255);
        random_pixels(40);
        drain_pipeline();

        if (error_count == 0) begin
            $display("hue_wheel_pixel_generator: match");
        end else begin
            $display("hue_wheel_pixel_generator: mismatch");
        end
        $finish;
    end

endmodule
